### src/periodic_particle_move_and_proximity_unit_defines.svh
// assertion macros for the periodic particle move and proximity unit
// used by the top level only; expects aclk and aresetn in scope
`ifndef PERIODIC_PARTICLE_MOVE_AND_PROXIMITY_UNIT_DEFINES_SVH
`define PERIODIC_PARTICLE_MOVE_AND_PROXIMITY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PPM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ppm check failed: same cycle");
`define PPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ppm check failed: next cycle");
`else
`define PPM_ASSERT_NOW(lbl, ante, cons)
`define PPM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/ppm_pkg.sv
// shared constants, codes and types of the particle move and proximity unit
// no dependencies
package ppm_pkg;

    localparam int PARTICLES  = 16;
    localparam int POS_W      = 16;
    localparam int VAL_W      = 16;
    localparam int IDX_W      = $clog2(PARTICLES);
    localparam int SUM_W      = POS_W + 2;
    localparam int MAG_W      = POS_W + 1;
    localparam int GAP_W      = POS_W + 1;
    localparam int R2_W       = 2 * POS_W;
    localparam int WRAP_STEPS = MAG_W;
    localparam int STEP_W     = $clog2(WRAP_STEPS + 1);
    localparam int RESULT_CAP = 16;
    localparam int CNT_W      = $clog2(RESULT_CAP);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 16;
    localparam int S_DATA_W   = ((IDX_W + 2 * VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((IDX_W + 2 * POS_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0] BOX_RESET    = POS_W'(2560);
    localparam logic [POS_W-1:0] RADIUS_RESET = POS_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_SIZE     = 1'b0,
        CFG_CLOSE_RADIUS = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_MOVE = 1'b1
    } action_t;

    typedef enum logic {
        KIND_PAIR = 1'b0,
        KIND_POS  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRAP,
        ST_LAUNCH,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } pos_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] k;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } tok_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] k;
    } res_t;

endpackage

### src/ppm_wrap.sv
// two-lane true modulo unit: wraps a signed coordinate pair into [0, box)
// restoring remainder, one bit per cycle; depends on ppm_pkg
module ppm_wrap (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [ppm_pkg::SUM_W-1:0] val_x,
    input  logic signed [ppm_pkg::SUM_W-1:0] val_y,
    input  logic        [ppm_pkg::POS_W-1:0] box,
    output logic                             busy,
    output logic                             done,
    output logic        [ppm_pkg::POS_W-1:0] res_x,
    output logic        [ppm_pkg::POS_W-1:0] res_y
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [ppm_pkg::STEP_W-1:0]       cnt_reg, cnt_next;
    logic [ppm_pkg::MAG_W-1:0]        mag_reg  [2];
    logic [ppm_pkg::POS_W-1:0]        rem_reg  [2];
    logic                             neg_reg  [2];
    logic [ppm_pkg::POS_W-1:0]        res_reg  [2];
    logic signed [ppm_pkg::SUM_W-1:0] vals     [2];
    logic [ppm_pkg::MAG_W-1:0]        mag_init [2];
    logic [ppm_pkg::POS_W-1:0]        rem_step [2];
    logic [ppm_pkg::POS_W-1:0]        rem_fin  [2];
    logic [ppm_pkg::MAG_W-1:0]        trial    [2];
    logic [ppm_pkg::MAG_W-1:0]        diff     [2];
    logic                             last_step;

    assign vals[0]   = val_x;
    assign vals[1]   = val_y;
    assign last_step = (cnt_reg == ppm_pkg::STEP_W'(ppm_pkg::WRAP_STEPS - 1));

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mag_init[l] = vals[l][ppm_pkg::SUM_W-1] ? ppm_pkg::MAG_W'(-vals[l])
                                                    : ppm_pkg::MAG_W'(vals[l]);
            trial[l]    = {rem_reg[l], mag_reg[l][ppm_pkg::MAG_W-1]};
            diff[l]     = trial[l] - {1'b0, box};
            rem_step[l] = (trial[l] >= {1'b0, box}) ? diff[l][ppm_pkg::POS_W-1:0]
                                                    : trial[l][ppm_pkg::POS_W-1:0];
            if (box == '0) begin
                rem_fin[l] = '0;
            end else if (neg_reg[l] && rem_step[l] != '0) begin
                rem_fin[l] = box - rem_step[l];
            end else begin
                rem_fin[l] = rem_step[l];
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (!busy_reg && start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        for (int l = 0; l < 2; l++) begin
            if (!busy_reg && start) begin
                mag_reg[l] <= mag_init[l];
                rem_reg[l] <= '0;
                neg_reg[l] <= vals[l][ppm_pkg::SUM_W-1];
            end else if (busy_reg) begin
                mag_reg[l] <= {mag_reg[l][ppm_pkg::MAG_W-2:0], 1'b0};
                rem_reg[l] <= rem_step[l];
                if (last_step) begin
                    res_reg[l] <= rem_fin[l];
                end
            end
        end
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign res_x = res_reg[0];
    assign res_y = res_reg[1];

endmodule

### src/ppm_cell.sv
// one particle cell: holds a position, compares the passing token against it
// by minimum-image squared distance and hands the token on; depends on ppm_pkg
module ppm_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic [ppm_pkg::POS_W-1:0]   box,
    input  logic [ppm_pkg::R2_W-1:0]    r2,
    input  logic                        wr_en,
    input  ppm_pkg::pos_t               wr_pos,
    input  ppm_pkg::tok_t               tok_in,
    output ppm_pkg::tok_t               tok_out,
    output ppm_pkg::res_t               res_out,
    output ppm_pkg::pos_t               pos_out
);

    function automatic logic signed [ppm_pkg::GAP_W-1:0] axis_gap(
        input logic [ppm_pkg::POS_W-1:0] a,
        input logic [ppm_pkg::POS_W-1:0] b,
        input logic [ppm_pkg::POS_W-1:0] side
    );
        logic [ppm_pkg::POS_W-1:0]        d;
        logic signed [ppm_pkg::GAP_W-1:0] ds;
        logic signed [ppm_pkg::GAP_W-1:0] alt;
        d   = (a >= b) ? (a - b) : (b - a);
        ds  = $signed({1'b0, d});
        alt = $signed({1'b0, side}) - ds;
        return (alt < ds) ? alt : ds;
    endfunction

    ppm_pkg::pos_t                      pos_reg;
    ppm_pkg::tok_t                      tok_reg;
    logic                               v1_reg, e1_reg;
    logic [ppm_pkg::IDX_W-1:0]          k1_reg;
    logic signed [ppm_pkg::GAP_W-1:0]   gx1_reg, gy1_reg;
    logic signed [ppm_pkg::GAP_W-1:0]   gx1_next, gy1_next;
    logic                               v2_reg, e2_reg;
    logic [ppm_pkg::IDX_W-1:0]          k2_reg;
    logic [ppm_pkg::R2_W-1:0]           sqx2_reg, sqy2_reg;
    logic signed [2*ppm_pkg::GAP_W-1:0] sqx_full, sqy_full;
    logic [ppm_pkg::R2_W:0]             dist2;
    ppm_pkg::res_t                      res_reg, res_next;
    ppm_pkg::tok_t                      fwd;

    // stage 1: per-axis minimum-image gaps
    assign gx1_next = axis_gap(tok_reg.x, pos_reg.x, box);
    assign gy1_next = axis_gap(tok_reg.y, pos_reg.y, box);

    // stage 2: squares
    assign sqx_full = gx1_reg * gx1_reg;
    assign sqy_full = gy1_reg * gy1_reg;

    // stage 3: sum and compare
    assign dist2 = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};

    always_comb begin
        res_next.valid = v2_reg;
        res_next.hit   = e2_reg && (dist2 < {1'b0, r2});
        res_next.k     = k2_reg;
    end

    always_comb begin
        fwd   = tok_reg;
        fwd.k = tok_reg.k + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pos_reg <= wr_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_reg.valid <= 1'b0;
        end else if (adv) begin
            tok_reg  <= tok_in;
            v1_reg   <= tok_reg.valid;
            e1_reg   <= tok_reg.valid && (tok_reg.k < tok_reg.p);
            k1_reg   <= tok_reg.k;
            gx1_reg  <= gx1_next;
            gy1_reg  <= gy1_next;
            v2_reg   <= v1_reg;
            e2_reg   <= e1_reg;
            k2_reg   <= k1_reg;
            sqx2_reg <= sqx_full[ppm_pkg::R2_W-1:0];
            sqy2_reg <= sqy_full[ppm_pkg::R2_W-1:0];
            res_reg  <= res_next;
        end
    end

    assign tok_out = fwd;
    assign res_out = res_reg;
    assign pos_out = pos_reg;

endmodule

### src/periodic_particle_move_and_proximity_unit.sv
// a load is stored in its cell once the 17-step modulo unit has wrapped it; a move
// wraps its new position, then launches a token that walks the cell row, each cell
// with a 3-stage compare; pair reports come first, at most one per cycle while the output
// is not stalled, then the position report; one item at a time, accepted only when idle
// reset (aresetn low, synchronous) clears control and restores box 10.0, radius 1.0
// depends on ppm_pkg, ppm_wrap, ppm_cell and the defines header
`include "periodic_particle_move_and_proximity_unit_defines.svh"

module periodic_particle_move_and_proximity_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppm_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // particle, value_x, value_y (zero padded)
    input  logic [ppm_pkg::S_DATA_W-1:0]      s_tdata,
    // action
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // other_particle, pos_x_out, pos_y_out (zero padded)
    output logic [ppm_pkg::M_DATA_W-1:0]      m_tdata,
    // report_kind
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int N = ppm_pkg::PARTICLES;

    ppm_pkg::state_t                  state_reg, state_next;
    logic [ppm_pkg::POS_W-1:0]        box_reg, radius_reg;
    logic [ppm_pkg::R2_W-1:0]         r2_reg;
    logic [ppm_pkg::IDX_W-1:0]        p_reg;
    ppm_pkg::action_t                 act_reg;
    logic [ppm_pkg::POS_W-1:0]        nx_reg, ny_reg;
    logic [ppm_pkg::CNT_W-1:0]        cnt_reg, cnt_next;

    logic                             out_valid_reg, out_valid_next;
    ppm_pkg::kind_t                   out_kind_reg, out_kind_next;
    logic [ppm_pkg::IDX_W-1:0]        out_other_reg, out_other_next;
    logic [ppm_pkg::POS_W-1:0]        out_x_reg, out_y_reg;
    logic                             out_last_reg, out_last_next;

    logic [ppm_pkg::IDX_W-1:0]        in_p;
    logic [ppm_pkg::VAL_W-1:0]        in_vx, in_vy;
    ppm_pkg::action_t                 in_act;
    logic                             in_accept, in_range;
    logic signed [ppm_pkg::SUM_W-1:0] vx_ext, vy_ext, wrap_x, wrap_y;
    ppm_pkg::pos_t                    sel_pos;

    logic                             wrap_start, wrap_busy, wrap_done;
    logic [ppm_pkg::POS_W-1:0]        wrap_rx, wrap_ry;

    logic                             adv;
    ppm_pkg::tok_t                    tok  [N+1];
    ppm_pkg::res_t                    res  [N];
    ppm_pkg::pos_t                    cpos [N];
    logic [N-1:0]                     wr_en_vec;
    logic [N-1:0]                     res_valid_vec;
    logic [N-1:0]                     tok_valid_vec;
    ppm_pkg::pos_t                    wr_pos;
    logic                             hit_any, chain_end, take_pair, take_pos;
    logic [ppm_pkg::IDX_W-1:0]        hit_k;

    // input unpacking
    assign in_p     = s_tdata[ppm_pkg::IDX_W-1:0];
    assign in_vx    = s_tdata[ppm_pkg::IDX_W +: ppm_pkg::VAL_W];
    assign in_vy    = s_tdata[ppm_pkg::IDX_W + ppm_pkg::VAL_W +: ppm_pkg::VAL_W];
    assign in_act   = ppm_pkg::action_t'(s_tuser);
    assign s_tready = (state_reg == ppm_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_range  = ({1'b0, in_p} < (ppm_pkg::IDX_W + 1)'(N));

    assign vx_ext  = ppm_pkg::SUM_W'($signed(in_vx));
    assign vy_ext  = ppm_pkg::SUM_W'($signed(in_vy));
    assign sel_pos = cpos[in_p];

    always_comb begin
        if (in_act == ppm_pkg::ACT_MOVE) begin
            wrap_x = $signed({2'b00, sel_pos.x}) + vx_ext;
            wrap_y = $signed({2'b00, sel_pos.y}) + vy_ext;
        end else begin
            wrap_x = vx_ext;
            wrap_y = vy_ext;
        end
    end

    assign wrap_start = in_accept && in_range;

    ppm_wrap u_wrap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (wrap_start),
        .val_x   (wrap_x),
        .val_y   (wrap_y),
        .box     (box_reg),
        .busy    (wrap_busy),
        .done    (wrap_done),
        .res_x   (wrap_rx),
        .res_y   (wrap_ry)
    );

    // cell row
    assign adv = !out_valid_reg || m_tready;

    always_comb begin
        tok[0].valid = (state_reg == ppm_pkg::ST_LAUNCH);
        tok[0].p     = p_reg;
        tok[0].k     = '0;
        tok[0].x     = nx_reg;
        tok[0].y     = ny_reg;
    end

    assign wr_pos.x = wrap_rx;
    assign wr_pos.y = wrap_ry;

    for (genvar i = 0; i < N; i++) begin : g_cell
        assign wr_en_vec[i] = wrap_done && (state_reg == ppm_pkg::ST_WRAP)
                              && (p_reg == ppm_pkg::IDX_W'(i));

        ppm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .box     (box_reg),
            .r2      (r2_reg),
            .wr_en   (wr_en_vec[i]),
            .wr_pos  (wr_pos),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .res_out (res[i]),
            .pos_out (cpos[i])
        );

        assign res_valid_vec[i] = res[i].valid;
        assign tok_valid_vec[i] = tok[i+1].valid;
    end

    // at most one cell reports per cycle
    always_comb begin
        hit_any = 1'b0;
        hit_k   = '0;
        for (int i = 0; i < N; i++) begin
            if (res[i].valid && res[i].hit) begin
                hit_any = 1'b1;
                hit_k   = hit_k | res[i].k;
            end
        end
    end

    assign chain_end = res[N-1].valid;
    assign take_pair = hit_any && (cnt_reg < ppm_pkg::CNT_W'(ppm_pkg::RESULT_CAP - 1));
    assign take_pos  = (state_reg == ppm_pkg::ST_RUN) && chain_end;

    // control
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ppm_pkg::ST_IDLE: begin
                if (wrap_start) begin
                    state_next = ppm_pkg::ST_WRAP;
                end
            end
            ppm_pkg::ST_WRAP: begin
                if (wrap_done) begin
                    state_next = (act_reg == ppm_pkg::ACT_MOVE) ? ppm_pkg::ST_LAUNCH
                                                                : ppm_pkg::ST_IDLE;
                end
            end
            ppm_pkg::ST_LAUNCH: begin
                if (adv) begin
                    state_next = ppm_pkg::ST_RUN;
                    cnt_next   = '0;
                end
            end
            ppm_pkg::ST_RUN: begin
                if (adv && take_pair) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (adv && take_pos) begin
                    state_next = ppm_pkg::ST_IDLE;
                end
            end
            default: state_next = ppm_pkg::ST_IDLE;
        endcase
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_other_next = out_other_reg;
        out_last_next  = out_last_reg;
        if (adv) begin
            out_valid_next = 1'b0;
            if (take_pos) begin
                out_valid_next = 1'b1;
                out_kind_next  = ppm_pkg::KIND_POS;
                out_other_next = '0;
                out_last_next  = 1'b1;
            end else if (take_pair) begin
                out_valid_next = 1'b1;
                out_kind_next  = ppm_pkg::KIND_PAIR;
                out_other_next = hit_k;
                out_last_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ppm_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            box_reg       <= ppm_pkg::BOX_RESET;
            radius_reg    <= ppm_pkg::RADIUS_RESET;
            r2_reg        <= ppm_pkg::R2_W'(ppm_pkg::RADIUS_RESET)
                             * ppm_pkg::R2_W'(ppm_pkg::RADIUS_RESET);
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            r2_reg        <= ppm_pkg::R2_W'(radius_reg) * ppm_pkg::R2_W'(radius_reg);
            if (cfg_we) begin
                unique case (ppm_pkg::cfg_idx_t'(cfg_index))
                    ppm_pkg::CFG_BOX_SIZE:     box_reg    <= cfg_wdata[ppm_pkg::POS_W-1:0];
                    ppm_pkg::CFG_CLOSE_RADIUS: radius_reg <= cfg_wdata[ppm_pkg::POS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg  <= out_kind_next;
        out_other_reg <= out_other_next;
        out_last_reg  <= out_last_next;
        if (in_accept) begin
            p_reg   <= in_p;
            act_reg <= in_act;
        end
        if (wrap_done) begin
            nx_reg <= wrap_rx;
            ny_reg <= wrap_ry;
        end
        if (adv && (take_pos || take_pair)) begin
            out_x_reg <= nx_reg;
            out_y_reg <= ny_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ppm_pkg::M_DATA_W'({out_y_reg, out_x_reg, out_other_reg});
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `PPM_ASSERT_NOW(a_no_accept_in_flight, in_accept, (tok_valid_vec == '0) && !wrap_busy)
    `PPM_ASSERT_NOW(a_one_cell_reports, 1'b1, $onehot0(res_valid_vec))
    `PPM_ASSERT_NOW(a_wrap_done_in_wrap, wrap_done, state_reg == ppm_pkg::ST_WRAP)
    `PPM_ASSERT_NEXT(a_end_gives_last, adv && take_pos, m_tvalid && m_tlast)

endmodule
